// ----- rtl/btmx_pkg.sv -----
// shared constants, codes and types for the binary trie max-xor block
package btmx_pkg;

  // width of the key and max_xor fields on the channels
  localparam int FIELD_W = 44;
  localparam int STATUS_W = 2;

  // defaults for the top-level parameters
  localparam int KEY_BITS_DEF = 44;
  localparam int NODE_COUNT_DEF = 4096;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // control of the bit-serial key and result registers
  typedef struct packed {
    logic load;
    logic shift;
    logic acc_in;
  } digit_ctl_t;

endpackage

// ----- rtl/btmx_if.sv -----
// valid/ready channel interfaces for request and response items
interface btmx_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [btmx_pkg::FIELD_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface btmx_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [btmx_pkg::FIELD_W-1:0]  max_xor;
  logic [btmx_pkg::STATUS_W-1:0] status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink (input valid, input max_xor, input status, output ready);
endinterface

// ----- rtl/btmx_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module btmx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/btmx_digit.sv -----
// bit-serial key shifter and result accumulator, msb first
module btmx_digit #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF
) (
  input  logic                 clk,
  input  btmx_pkg::digit_ctl_t ctl,
  input  logic [KEY_BITS-1:0]  key_in,
  output logic                 key_bit,
  output logic [KEY_BITS-1:0]  acc
);

  logic [KEY_BITS-1:0] key_sr;

  // key shifts out one bit per level, result bits shift in behind
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_sr <= key_in;
      acc <= '0;
    end else if (ctl.shift) begin
      key_sr <= key_sr << 1;
      acc <= (acc << 1) | KEY_BITS'(ctl.acc_in);
    end
  end

  assign key_bit = key_sr[KEY_BITS-1];

endmodule

// ----- rtl/binary_trie_max_xor.sv -----
// top level: binary trie over stored keys answering maximum-xor queries
//
//   channel | dir | payload          | notes
//   req     | in  | op, key          | op 0 insert, op 1 query
//   rsp     | out | max_xor, status  | one item per request
//
// one node memory read per key bit sets the pace: a query walks every level
// from accept to result. an insert walks the levels its prefix matches, then
// makes one write per new node plus one leaf write. a query on an empty trie
// skips the walk and a full insert ends right after it. reset needs no
// clearing pass; the root reads as empty until the first insert. a request
// is accepted while an earlier result still waits.
module binary_trie_max_xor #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  btmx_req_if.sink   req,
  btmx_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int ENT_W = 2 * IDX_W;
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int LVL_W = $clog2(KEY_BITS + 1);
  localparam int CMP_W = (CNT_W > LVL_W) ? CNT_W : LVL_W;
  localparam int WIDE_W = (KEY_BITS > btmx_pkg::FIELD_W) ? KEY_BITS : btmx_pkg::FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_LEAF,
    S_FIN
  } state_t;

  state_t               state, state_next;
  logic                 op_r, op_next;
  logic [LVL_W-1:0]     lvl, lvl_next;
  logic [IDX_W-1:0]     nd, nd_next;
  logic [CNT_W-1:0]     used, used_next;
  logic                 holds, holds_next;
  logic                 dead, dead_next;
  logic [ENT_W-1:0]     ent_r, ent_next;
  btmx_pkg::status_t    stat_r, stat_next;
  logic                 out_valid;
  logic [btmx_pkg::FIELD_W-1:0] out_xor;
  btmx_pkg::status_t    out_stat;

  // memory ports
  logic                 we;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [ENT_W-1:0]     wdata, rdata;

  // bit-serial datapath
  btmx_pkg::digit_ctl_t dctl;
  logic                 key_bit;
  logic [KEY_BITS-1:0]  acc;
  logic [WIDE_W-1:0]    wide_key, wide_acc;
  logic [KEY_BITS-1:0]  key_fit;

  // walk helpers
  logic [ENT_W-1:0]     entry;
  logic [IDX_W-1:0]     child0, child1, link_same, link_opp;
  logic [CNT_W-1:0]     free_cnt;
  logic                 last_lvl;

  btmx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_links (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  btmx_digit #(
    .KEY_BITS (KEY_BITS)
  ) u_digit (
    .clk     (clk),
    .ctl     (dctl),
    .key_in  (key_fit),
    .key_bit (key_bit),
    .acc     (acc)
  );

  // fit the key field to the trie depth and the result back to the field
  assign wide_key = WIDE_W'(req.key);
  assign key_fit = wide_key[KEY_BITS-1:0];
  assign wide_acc = WIDE_W'(acc);

  // current node entry; the root reads as empty before the first insert
  assign entry = (lvl == LVL_W'(KEY_BITS) && !holds) ? '0 : rdata;
  assign child0 = entry[IDX_W-1:0];
  assign child1 = entry[ENT_W-1:IDX_W];
  assign link_same = key_bit ? child1 : child0;
  assign link_opp = key_bit ? child0 : child1;
  assign free_cnt = CNT_W'(NODE_COUNT) - used;
  assign last_lvl = (lvl == LVL_W'(1));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.max_xor = out_xor;
  assign rsp.status = out_stat;

  // next-state and datapath control
  always_comb begin
    state_next = state;
    op_next = op_r;
    lvl_next = lvl;
    nd_next = nd;
    used_next = used;
    holds_next = holds;
    dead_next = dead;
    ent_next = ent_r;
    stat_next = stat_r;
    dctl = '0;
    we = 1'b0;
    waddr = nd;
    wdata = '0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          dctl.load = 1'b1;
          op_next = req.op;
          lvl_next = LVL_W'(KEY_BITS);
          nd_next = '0;
          dead_next = 1'b0;
          stat_next = btmx_pkg::ST_OK;
          if (req.op == btmx_pkg::OP_QUERY && !holds) begin
            stat_next = btmx_pkg::ST_EMPTY;
            state_next = S_FIN;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (op_r == btmx_pkg::OP_QUERY) begin
          // prefer the opposite child, fall back to the same one
          dctl.shift = 1'b1;
          lvl_next = lvl - LVL_W'(1);
          if (!dead) begin
            if (link_opp != '0) begin
              dctl.acc_in = 1'b1;
              nd_next = link_opp;
            end else if (link_same != '0) begin
              nd_next = link_same;
            end else begin
              dead_next = 1'b1;
            end
          end
          raddr = nd_next;
          if (last_lvl) begin
            state_next = S_FIN;
          end
        end else begin
          // follow the stored prefix until a child is missing
          if (link_same != '0) begin
            dctl.shift = 1'b1;
            lvl_next = lvl - LVL_W'(1);
            nd_next = link_same;
            raddr = link_same;
            if (last_lvl) begin
              state_next = S_FIN;
            end
          end else begin
            ent_next = entry;
            if (CMP_W'(lvl) > CMP_W'(free_cnt)) begin
              stat_next = btmx_pkg::ST_FULL;
              state_next = S_FIN;
            end else begin
              state_next = S_ALLOC;
            end
          end
        end
      end
      S_ALLOC: begin
        // link the next new node below the current one
        we = 1'b1;
        waddr = nd;
        wdata = ent_r;
        if (key_bit) begin
          wdata[ENT_W-1:IDX_W] = used[IDX_W-1:0];
        end else begin
          wdata[IDX_W-1:0] = used[IDX_W-1:0];
        end
        nd_next = used[IDX_W-1:0];
        used_next = used + CNT_W'(1);
        ent_next = '0;
        dctl.shift = 1'b1;
        lvl_next = lvl - LVL_W'(1);
        if (last_lvl) begin
          state_next = S_LEAF;
        end
      end
      S_LEAF: begin
        // leaf gets cleared children
        we = 1'b1;
        waddr = nd;
        wdata = '0;
        holds_next = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, walk registers and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= CNT_W'(1);
      holds <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      holds <= holds_next;
      if (state == S_FIN && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
        out_xor <= (op_r == btmx_pkg::OP_QUERY) ? wide_acc[btmx_pkg::FIELD_W-1:0] : '0;
        out_stat <= stat_r;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    op_r <= op_next;
    lvl <= lvl_next;
    nd <= nd_next;
    dead <= dead_next;
    ent_r <= ent_next;
    stat_r <= stat_next;
  end

`ifndef SYNTH
  // the node count never passes the store size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(NODE_COUNT) >= used)
    else $error("node count beyond store size");

  // allocation only writes below the next free node
  a_alloc_addr: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> CNT_W'(nd) < used)
    else $error("link written into an unallocated node");

  // once a key is stored the trie never reads as empty again
  a_holds_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(holds))
    else $error("stored-key flag dropped");

  // an empty status always carries a zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == btmx_pkg::ST_EMPTY |-> rsp.max_xor == '0)
    else $error("empty query with nonzero result");

  // an accepted item leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("item accepted but no work started");
`endif

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the binary trie max-xor block
`timescale 1ns / 1ps

module testbench;

  localparam int KEY_BITS = btmx_pkg::KEY_BITS_DEF;
  localparam int NODE_COUNT = btmx_pkg::NODE_COUNT_DEF;
  localparam int FIELD_W = btmx_pkg::FIELD_W;
  localparam int POOL_SIZE = 8;
  localparam int DRAIN_CYCLES = KEY_BITS + 8;
  localparam logic [FIELD_W-1:0] ALL_ONES = '1;
  localparam logic [FIELD_W-1:0] TOP_BIT = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] ALT_BITS = {11{4'h5}};

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] key;
  } req_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] max_xor;
    btmx_pkg::status_t  status;
  } xor_result_t;

  logic clk;
  logic rst;

  btmx_req_if req_ch ();
  btmx_rsp_if rsp_ch ();

  binary_trie_max_xor #(
    .KEY_BITS(KEY_BITS),
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  req_item_t pending_reqs[$];
  xor_result_t xor_results_due[$];
  logic [FIELD_W-1:0] inserted_keys[$];
  logic [FIELD_W-1:0] key_pool[POOL_SIZE];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;

  // shadow trie: one link pair per node, index 0 means no child
  int unsigned zero_link[NODE_COUNT];
  int unsigned one_link[NODE_COUNT];
  int unsigned trie_nodes_used = 1;
  bit trie_has_keys = 1'b0;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // insert or query against the shadow trie, giving the result it causes
  function automatic xor_result_t trie_apply(input logic op,
                                             input logic [FIELD_W-1:0] key);
    xor_result_t res;
    int pos;
    int unsigned nd;
    int unsigned nx;
    int unsigned opp;
    int unsigned same;
    int unsigned need;
    bit walking;
    res.max_xor = '0;
    res.status = btmx_pkg::ST_OK;
    nd = 0;
    pos = KEY_BITS - 1;
    walking = 1'b1;
    if (op == btmx_pkg::OP_INSERT) begin
      // follow the existing prefix
      while (pos >= 0 && walking) begin
        nx = key[pos] ? one_link[nd] : zero_link[nd];
        if (nx == 0) begin
          walking = 1'b0;
        end else begin
          nd = nx;
          pos--;
        end
      end
      need = pos + 1;
      if (trie_nodes_used + need > NODE_COUNT) begin
        res.status = btmx_pkg::ST_FULL;
      end else begin
        // allocate the missing tail
        while (pos >= 0) begin
          nx = trie_nodes_used;
          trie_nodes_used++;
          zero_link[nx] = 0;
          one_link[nx] = 0;
          if (key[pos]) one_link[nd] = nx;
          else zero_link[nd] = nx;
          nd = nx;
          pos--;
        end
        trie_has_keys = 1'b1;
      end
    end else if (!trie_has_keys) begin
      res.status = btmx_pkg::ST_EMPTY;
    end else begin
      // greedy walk toward the opposite bit
      while (pos >= 0 && walking) begin
        opp = key[pos] ? zero_link[nd] : one_link[nd];
        same = key[pos] ? one_link[nd] : zero_link[nd];
        if (opp != 0) begin
          res.max_xor[pos] = 1'b1;
          nd = opp;
        end else if (same != 0) begin
          nd = same;
        end else begin
          walking = 1'b0;
        end
        pos--;
      end
    end
    return res;
  endfunction

  // key mix: pool neighbors, repeats of inserted keys, full random keys
  function automatic logic [FIELD_W-1:0] pick_key(input logic op, input int rand_pct);
    logic [63:0] noise;
    logic [FIELD_W-1:0] k;
    int sel;
    int width;
    noise = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < rand_pct) begin
      k = noise[FIELD_W-1:0];
    end else if (sel < rand_pct + 15 && inserted_keys.size() != 0) begin
      k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    end else begin
      width = $urandom_range(12);
      k = key_pool[$urandom_range(POOL_SIZE - 1)]
          ^ (noise[FIELD_W-1:0] & ((44'd1 << width) - 44'd1));
      // queries near a complement find long xor runs
      if (op == btmx_pkg::OP_QUERY && $urandom_range(1) == 1) k = ~k;
    end
    return k;
  endfunction

  task automatic push_item(input logic op, input logic [FIELD_W-1:0] key);
    req_item_t it;
    it.op = op;
    it.key = key;
    pending_reqs.insert(pending_reqs.size(), it);
    if (op == btmx_pkg::OP_INSERT) inserted_keys.insert(inserted_keys.size(), key);
  endtask

  // hold the sender until every item is through and every result is back
  task automatic drain_all();
    while (pending_reqs.size() != 0 || req_ch.valid || xor_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int idle, input int stall,
                              input int rand_pct);
    logic op;
    drain_all();
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(1) ? btmx_pkg::OP_QUERY : btmx_pkg::OP_INSERT;
      push_item(op, pick_key(op, rand_pct));
    end
  endtask

  // request driver
  always @(posedge clk) begin : driver
    req_item_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.op <= nxt.op;
        req_ch.key <= nxt.key;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response stalls
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // monitor: check results, then predict for accepted requests
  always @(posedge clk) begin : monitor
    xor_result_t due;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (xor_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result max_xor=%h status=%0d",
                     $realtime, rsp_ch.max_xor, rsp_ch.status);
        end else begin
          due = xor_results_due.pop_front();
          if (rsp_ch.max_xor !== due.max_xor || rsp_ch.status !== due.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: exp max_xor=%h status=%0d, got max_xor=%h status=%0d",
                       $realtime, due.max_xor, due.status, rsp_ch.max_xor,
                       rsp_ch.status);
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        xor_results_due.insert(xor_results_due.size(), trie_apply(req_ch.op, req_ch.key));
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = btmx_pkg::OP_INSERT;
    req_ch.key = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      zero_link[i] = 0;
      one_link[i] = 0;
    end
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = FIELD_W'({$urandom, $urandom});
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty trie, extremes, duplicates, alternating patterns
    push_item(btmx_pkg::OP_QUERY, '0);
    push_item(btmx_pkg::OP_QUERY, ALL_ONES);
    push_item(btmx_pkg::OP_INSERT, '0);
    push_item(btmx_pkg::OP_QUERY, '0);
    push_item(btmx_pkg::OP_QUERY, ALL_ONES);
    push_item(btmx_pkg::OP_INSERT, '0);
    push_item(btmx_pkg::OP_INSERT, ALL_ONES);
    push_item(btmx_pkg::OP_QUERY, '0);
    push_item(btmx_pkg::OP_QUERY, TOP_BIT);
    push_item(btmx_pkg::OP_QUERY, ALL_ONES);
    push_item(btmx_pkg::OP_INSERT, 44'd1);
    push_item(btmx_pkg::OP_QUERY, 44'd1);
    push_item(btmx_pkg::OP_QUERY, ALL_ONES ^ 44'd1);
    push_item(btmx_pkg::OP_INSERT, ALT_BITS);
    push_item(btmx_pkg::OP_INSERT, ~ALT_BITS);
    push_item(btmx_pkg::OP_QUERY, ALT_BITS);
    push_item(btmx_pkg::OP_QUERY, ~ALT_BITS);
    push_item(btmx_pkg::OP_INSERT, TOP_BIT);
    push_item(btmx_pkg::OP_QUERY, ~TOP_BIT);

    // random phases
    random_phase(410, 0, 0, 5);
    random_phase(410, 85, 0, 5);
    random_phase(410, 0, 85, 10);
    random_phase(410, 27, 27, 30);

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && xor_results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- binary_trie_max_xor.f -----
rtl/btmx_pkg.sv
rtl/btmx_if.sv
rtl/btmx_ram.sv
rtl/btmx_digit.sv
rtl/binary_trie_max_xor.sv
verif/testbench.sv
